[design/fbrs_pkg.sv]
// Shared types, codes and the color expansion function of the run-span scan-out block.
package fbrs_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd4;

    // Input word actions.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SCAN  = 2'd2;

    // One input word.
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         pixel;
    } t_in_word;

    // One result word: a scaled rectangle covering one run.
    typedef struct packed {
        logic [10:0] rect_x;
        logic [10:0] rect_y;
        logic [11:0] rect_w;
        logic [4:0]  rect_h;
        logic [15:0] rect_color;
        logic        last_result;
        logic        frame_end;
    } t_out_word;

    // Control that goes with one run descriptor handed to the formatter.
    typedef struct packed {
        logic push;
        logic last_result;
        logic frame_end;
    } t_emit_ctl;

    // Expands a stored byte to 16-bit color: duplicated byte or grey spread to RGB565.
    function automatic logic [15:0] fbrs_expand(input logic [7:0] p, input logic dup_mode);
        logic [15:0] c;
        if (dup_mode) begin
            c = {p, p};
        end else begin
            c = {p[7:3], p[7:2], p[7:3]};
        end
        return c;
    endfunction

endpackage

[design/fbrs_stream_if.sv]
// Valid/ready stream interface that carries one word of a chosen type.
interface fbrs_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/fbrs_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
module fbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/fbrs_rect.sv]
// Scales a run descriptor into a rectangle word and holds it in the output register.
module fbrs_rect #(
    parameter int CW = 7,
    parameter int RW = 7,
    parameter int WN = 8,
    parameter int SN = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fbrs_pkg::t_emit_ctl  i_ctl,
    input  logic [CW-1:0]        i_start,
    input  logic [WN-1:0]        i_len,
    input  logic [RW-1:0]        i_row,
    input  logic [15:0]          i_color,
    input  logic [SN-1:0]        i_scale_x,
    input  logic [SN-1:0]        i_scale_y,
    output logic                 o_can_push,
    fbrs_stream_if.source        o_out
);
    import fbrs_pkg::*;

    logic        r_valid;
    t_out_word   r_word;
    t_out_word   n_word;

    logic [CW+SN-1:0] x_prod;
    logic [RW+SN-1:0] y_prod;
    logic [WN+SN-1:0] w_prod;

    // The register is free when empty or when its word leaves this cycle.
    assign o_can_push = !r_valid || o_out.ready;

    // Scale the run into rectangle coordinates; products are cut to the field widths.
    always_comb begin
        x_prod = (CW+SN)'(i_start) * (CW+SN)'(i_scale_x);
        y_prod = (RW+SN)'(i_row) * (RW+SN)'(i_scale_y);
        w_prod = (WN+SN)'(i_len) * (WN+SN)'(i_scale_x);
        n_word.rect_x      = 11'(x_prod);
        n_word.rect_y      = 11'(y_prod);
        n_word.rect_w      = 12'(w_prod);
        n_word.rect_h      = 5'(i_scale_y);
        n_word.rect_color  = i_color;
        n_word.last_result = i_ctl.last_result;
        n_word.frame_end   = i_ctl.frame_end;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (i_ctl.push) begin
            r_word <= n_word;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;
endmodule

[design/framebuffer_run_span_scanout.sv]
// Top level of the run-span framebuffer scan-out: store, scan sequencer and run merging.
// The block keeps an 8-bit MAX_WIDTH x MAX_HEIGHT framebuffer in one synchronous RAM,
// laid out row by row with a pitch of the active width. A write word is stored in the
// cycle it is taken and is dropped when it falls outside the active area. A scan word
// reads the next pixel in raster order: the RAM read, then the color compare, then one
// emit step for each rectangle it produces, held while the output register is stalled.
// A clear word, and also reset, start a clearing pass that writes one RAM entry per
// cycle over all MAX_WIDTH * MAX_HEIGHT entries, during which no input word is taken;
// configuration writes are taken at any time. Results leave through a single output
// register, so a new input word is taken while a rectangle still waits there.
module framebuffer_run_span_scanout #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_SCALE  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbrs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fbrs_stream_if.sink                      i_in,
    fbrs_stream_if.source                    o_out
);
    import fbrs_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WN    = $clog2(MAX_WIDTH + 1);
    localparam int HN    = $clog2(MAX_HEIGHT + 1);
    localparam int SN    = $clog2(MAX_SCALE + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Configuration registers, kept raw and clamped on use.
    logic        r_color_mode;
    logic [7:0]  r_width;
    logic [7:0]  r_height;
    logic [4:0]  r_scale_x;
    logic [4:0]  r_scale_y;

    // Control state.
    logic [1:0]    r_state,    n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [RW-1:0] r_scan_row, n_scan_row;
    logic [AW-1:0] r_scan_addr, n_scan_addr;
    logic [CW-1:0] r_run_start, n_run_start;
    logic [15:0]   r_run_color, n_run_color;
    logic          r_has_a, n_has_a;
    logic          r_has_b, n_has_b;

    // Pending run descriptors: A closes a run on a color change, B closes the row.
    logic [CW-1:0] r_a_start, n_a_start;
    logic [WN-1:0] r_a_len,   n_a_len;
    logic [15:0]   r_a_color, n_a_color;
    logic          r_a_last,  n_a_last;
    logic [CW-1:0] r_b_start, n_b_start;
    logic [WN-1:0] r_b_len,   n_b_len;
    logic [15:0]   r_b_color, n_b_color;
    logic          r_b_fend,  n_b_fend;
    logic [RW-1:0] r_desc_row, n_desc_row;

    // Clamped configuration.
    logic [WN-1:0] act_w;
    logic [HN-1:0] act_h;
    logic [SN-1:0] act_sx;
    logic [SN-1:0] act_sy;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // Write addressing and scan evaluation.
    logic          in_accept;
    logic          wr_inside;
    logic [RW+WN-1:0] wr_prod;
    logic [AW-1:0] wr_addr;
    logic [15:0]   pix_color;
    logic          run_first;
    logic          run_break;
    logic          row_end;
    logic          frame_row;
    logic [CW-1:0] new_start;
    logic [15:0]   new_color;

    // Formatter connection.
    t_emit_ctl     emit_ctl;
    logic          emit_can_push;
    logic [CW-1:0] emit_start;
    logic [WN-1:0] emit_len;
    logic [15:0]   emit_color;

    // Saturate geometry and scale registers to their legal ranges.
    always_comb begin
        if (r_width == 8'd0) begin
            act_w = WN'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            act_w = WN'(MAX_WIDTH);
        end else begin
            act_w = WN'(r_width);
        end
        if (r_height == 8'd0) begin
            act_h = HN'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            act_h = HN'(MAX_HEIGHT);
        end else begin
            act_h = HN'(r_height);
        end
        if (r_scale_x == 5'd0) begin
            act_sx = SN'(1);
        end else if (32'(r_scale_x) > 32'(MAX_SCALE)) begin
            act_sx = SN'(MAX_SCALE);
        end else begin
            act_sx = SN'(r_scale_x);
        end
        if (r_scale_y == 5'd0) begin
            act_sy = SN'(1);
        end else if (32'(r_scale_y) > 32'(MAX_SCALE)) begin
            act_sy = SN'(MAX_SCALE);
        end else begin
            act_sy = SN'(r_scale_y);
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    // Clip a write against the active area and form its row-major address.
    always_comb begin
        wr_inside = !i_in.data.pos_x[15] && !i_in.data.pos_y[15]
                    && ($unsigned(i_in.data.pos_x) < 16'(act_w))
                    && ($unsigned(i_in.data.pos_y) < 16'(act_h));
        wr_prod   = (RW+WN)'(i_in.data.pos_y[RW-1:0]) * (RW+WN)'(act_w);
        wr_addr   = AW'(wr_prod) + AW'(i_in.data.pos_x[CW-1:0]);
    end

    // RAM write port: the clearing pass or an accepted write inside the area.
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = in_accept && (i_in.data.action == ACT_WRITE) && wr_inside;
            ram_waddr = wr_addr;
            ram_wdata = i_in.data.pixel;
        end
    end

    fbrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (ram_rdata)
    );

    // Compare the pixel just read with the open run.
    always_comb begin
        pix_color = fbrs_expand(ram_rdata, r_color_mode);
        run_first = (r_scan_col == '0);
        run_break = !run_first && (pix_color != r_run_color);
        row_end   = (WN'(r_scan_col) == (act_w - WN'(1)));
        frame_row = (HN'(r_scan_row) == (act_h - HN'(1)));
        if (run_first) begin
            new_start = '0;
        end else if (run_break) begin
            new_start = r_scan_col;
        end else begin
            new_start = r_run_start;
        end
        new_color = (run_first || run_break) ? pix_color : r_run_color;
    end

    // Select the pending descriptor for the formatter.
    always_comb begin
        emit_ctl.push = (r_state == ST_EMIT) && emit_can_push;
        if (r_has_a) begin
            emit_start           = r_a_start;
            emit_len             = r_a_len;
            emit_color           = r_a_color;
            emit_ctl.last_result = r_a_last;
            emit_ctl.frame_end   = 1'b0;
        end else begin
            emit_start           = r_b_start;
            emit_len             = r_b_len;
            emit_color           = r_b_color;
            emit_ctl.last_result = 1'b1;
            emit_ctl.frame_end   = r_b_fend;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_scan_col  = r_scan_col;
        n_scan_row  = r_scan_row;
        n_scan_addr = r_scan_addr;
        n_run_start = r_run_start;
        n_run_color = r_run_color;
        n_has_a     = r_has_a;
        n_has_b     = r_has_b;
        n_a_start   = r_a_start;
        n_a_len     = r_a_len;
        n_a_color   = r_a_color;
        n_a_last    = r_a_last;
        n_b_start   = r_b_start;
        n_b_len     = r_b_len;
        n_b_color   = r_b_color;
        n_b_fend    = r_b_fend;
        n_desc_row  = r_desc_row;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (i_in.data.action)
                        ACT_CLEAR: begin
                            n_state    = ST_CLEAR;
                            n_clr_addr = '0;
                        end
                        ACT_SCAN: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_run_start = new_start;
                n_run_color = new_color;
                n_desc_row  = r_scan_row;
                n_has_a     = run_break;
                n_has_b     = row_end;
                n_a_start   = r_run_start;
                n_a_len     = WN'(r_scan_col) - WN'(r_run_start);
                n_a_color   = r_run_color;
                n_a_last    = !row_end;
                n_b_start   = new_start;
                n_b_len     = WN'(r_scan_col) - WN'(new_start) + WN'(1);
                n_b_color   = new_color;
                n_b_fend    = frame_row;
                // Advance in raster order, wrapping at the end of the frame.
                if (row_end) begin
                    n_scan_col = '0;
                    if (frame_row) begin
                        n_scan_row  = '0;
                        n_scan_addr = '0;
                    end else begin
                        n_scan_row  = r_scan_row + RW'(1);
                        n_scan_addr = r_scan_addr + AW'(1);
                    end
                end else begin
                    n_scan_col  = r_scan_col + CW'(1);
                    n_scan_addr = r_scan_addr + AW'(1);
                end
                n_state = (run_break || row_end) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (emit_can_push) begin
                    if (r_has_a) begin
                        n_has_a = 1'b0;
                        if (!r_has_b) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_has_b = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A geometry change restarts the scan at the top left.
        if (i_cfg_we && ((i_cfg_index == REG_WIDTH) || (i_cfg_index == REG_HEIGHT))) begin
            n_scan_col  = '0;
            n_scan_row  = '0;
            n_scan_addr = '0;
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_scan_col  <= '0;
            r_scan_row  <= '0;
            r_scan_addr <= '0;
            r_run_start <= '0;
            r_run_color <= '0;
            r_has_a     <= 1'b0;
            r_has_b     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_scan_col  <= n_scan_col;
            r_scan_row  <= n_scan_row;
            r_scan_addr <= n_scan_addr;
            r_run_start <= n_run_start;
            r_run_color <= n_run_color;
            r_has_a     <= n_has_a;
            r_has_b     <= n_has_b;
        end
    end

    // Descriptor payload registers.
    always_ff @(posedge i_clk) begin
        r_a_start  <= n_a_start;
        r_a_len    <= n_a_len;
        r_a_color  <= n_a_color;
        r_a_last   <= n_a_last;
        r_b_start  <= n_b_start;
        r_b_len    <= n_b_len;
        r_b_color  <= n_b_color;
        r_b_fend   <= n_b_fend;
        r_desc_row <= n_desc_row;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b1;
            r_width      <= 8'd128;
            r_height     <= 8'd128;
            r_scale_x    <= 5'd1;
            r_scale_y    <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                REG_WIDTH:      r_width      <= i_cfg_data;
                REG_HEIGHT:     r_height     <= i_cfg_data;
                REG_SCALE_X:    r_scale_x    <= i_cfg_data[4:0];
                REG_SCALE_Y:    r_scale_y    <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    fbrs_rect #(
        .CW (CW),
        .RW (RW),
        .WN (WN),
        .SN (SN)
    ) u_rect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (emit_ctl),
        .i_start    (emit_start),
        .i_len      (emit_len),
        .i_row      (r_desc_row),
        .i_color    (emit_color),
        .i_scale_x  (act_sx),
        .i_scale_y  (act_sy),
        .o_can_push (emit_can_push),
        .o_out      (o_out)
    );
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the run-span framebuffer scan-out: a directed table, then random phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbrs_pkg::*;

    localparam int FB_W            = 128;
    localparam int FB_H            = 128;
    localparam int SCALE_MAX       = 16;
    localparam int N_PHASES        = 12;
    localparam int PHASE_WORDS     = 108;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    // The limit must outlast a clearing pass over all FB_W * FB_H entries, in which no input word is accepted.
    localparam int WATCHDOG_LIMIT  = 70000;
    localparam int MAX_REPORTS     = 40;

    // Action code that the block ignores, and a register index beyond the last one.
    localparam logic [1:0]           ACT_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    // One row of the directed table: a register write or an input word.
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_in_word              word;
        bit                    typed;
        t_out_word             rect;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fbrs_stream_if #(.t_data(t_in_word))  in_if ();
    fbrs_stream_if #(.t_data(t_out_word)) out_if ();

    framebuffer_run_span_scanout #(
        .MAX_WIDTH (FB_W),
        .MAX_HEIGHT(FB_H),
        .MAX_SCALE (SCALE_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Shadow copy of the framebuffer, the scan position and the registers.
    logic [7:0]  fb_shadow [FB_W*FB_H];
    int          scan_col_s;
    int          scan_row_s;
    int          run_start_s;
    logic [15:0] run_color_s;
    logic        mode_s;
    logic [7:0]  width_s;
    logic [7:0]  height_s;
    logic [4:0]  sx_s;
    logic [4:0]  sy_s;

    t_out_word   rect_expect_q [$];
    t_out_word   want_rect;
    t_stim_row   directed_rows [$];
    int          n_err;
    int          quiet_cycles;
    bit          tx_burst;
    bit          rx_burst;
    bit          hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int clamp_reg(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Pixel byte to 16-bit color under the current mode.
    function automatic logic [15:0] spread_color(logic [7:0] p);
        int c;
        if (mode_s) begin
            c = p * 257;
        end else begin
            c = ((p >> 3) << 11) | ((p >> 2) << 5) | (p >> 3);
        end
        return 16'(c);
    endfunction

    // Scaled rectangle of a run on the current scan row.
    function automatic t_out_word run_rect(int start, int len, logic [15:0] color, bit fend);
        t_out_word r;
        int        sx;
        int        sy;
        sx = clamp_reg(sx_s, SCALE_MAX);
        sy = clamp_reg(sy_s, SCALE_MAX);
        r.rect_x      = 11'(start * sx);
        r.rect_y      = 11'(scan_row_s * sy);
        r.rect_w      = 12'(len * sx);
        r.rect_h      = 5'(sy);
        r.rect_color  = color;
        r.last_result = 1'b0;
        r.frame_end   = fend;
        return r;
    endfunction

    // Applies one word to the shadow state and returns the rectangles it closes.
    function automatic int fb_predict(input t_in_word w, output t_out_word rects [2]);
        int          wa;
        int          ha;
        int          px;
        int          py;
        int          n;
        logic [15:0] c;
        wa = clamp_reg(width_s, FB_W);
        ha = clamp_reg(height_s, FB_H);
        px = w.pos_x;
        py = w.pos_y;
        n = 0;
        rects[0] = '0;
        rects[1] = '0;
        case (w.action)
            ACT_WRITE: begin
                if (px >= 0 && py >= 0 && px < wa && py < ha) begin
                    fb_shadow[py * wa + px] = w.pixel;
                end
            end
            ACT_CLEAR: begin
                foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
            end
            ACT_SCAN: begin
                if (scan_col_s >= wa) begin
                    scan_col_s = 0;
                    scan_row_s++;
                end
                if (scan_row_s >= ha) scan_row_s = 0;
                c = spread_color(fb_shadow[scan_row_s * wa + scan_col_s]);
                // A row always opens a fresh run; a color change closes the open one.
                if (scan_col_s == 0) begin
                    run_start_s = 0;
                    run_color_s = c;
                end else if (c != run_color_s) begin
                    rects[n] = run_rect(run_start_s, scan_col_s - run_start_s, run_color_s, 1'b0);
                    n++;
                    run_start_s = scan_col_s;
                    run_color_s = c;
                end
                if (scan_col_s == wa - 1) begin
                    rects[n] = run_rect(run_start_s, scan_col_s - run_start_s + 1, run_color_s,
                                        scan_row_s == ha - 1);
                    n++;
                end
                if (n > 0) rects[n-1].last_result = 1'b1;
                scan_col_s++;
                if (scan_col_s >= wa) begin
                    scan_col_s = 0;
                    scan_row_s++;
                    if (scan_row_s >= ha) scan_row_s = 0;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic void fb_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_COLOR_MODE: mode_s = d[0];
            REG_WIDTH: begin
                width_s    = d;
                scan_col_s = 0;
                scan_row_s = 0;
            end
            REG_HEIGHT: begin
                height_s   = d;
                scan_col_s = 0;
                scan_row_s = 0;
            end
            REG_SCALE_X: sx_s = d[4:0];
            REG_SCALE_Y: sy_s = d[4:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            if (n_err < MAX_REPORTS) begin
                $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
            end
            n_err++;
        end
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_extent(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'($urandom_range(1, span));
        if (r == 7) return 8'd0;
        if (r == 8) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'($urandom_range(1, SCALE_MAX));
        if (r < 6) return 8'd1;
        if (r < 8) return 8'(SCALE_MAX);
        if (r == 8) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly scans and in-area writes from a small palette, so that runs form.
    function automatic t_in_word random_word();
        t_in_word w;
        int       r;
        int       wa;
        int       ha;
        wa = clamp_reg(width_s, FB_W);
        ha = clamp_reg(height_s, FB_H);
        w.action = ACT_SCAN;
        w.pos_x  = 16'($urandom);
        w.pos_y  = 16'($urandom);
        w.pixel  = 8'($urandom);
        r = $urandom_range(0, 999);
        if (r < 560) begin
            w.action = ACT_SCAN;
        end else if (r < 900) begin
            w.action = ACT_WRITE;
            w.pos_x  = 16'($urandom_range(0, wa - 1));
            w.pos_y  = 16'($urandom_range(0, ha - 1));
            // 0x41 and 0x43 share a grey color but differ when duplicated.
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       w.pixel = 8'h00;
                    1:       w.pixel = 8'h41;
                    2:       w.pixel = 8'h43;
                    default: w.pixel = 8'hFF;
                endcase
            end
        end else if (r < 970) begin
            // Writes just outside the area, or anywhere at all.
            w.action = ACT_WRITE;
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    w.pos_x = 16'(wa);
                    w.pos_y = 16'($urandom_range(0, ha - 1));
                end
                2: begin
                    w.pos_x = 16'($urandom_range(0, wa - 1));
                    w.pos_y = 16'(ha);
                end
                default: begin
                    w.pos_x = $urandom_range(0, 1) ? '1 : 16'($urandom_range(0, wa - 1));
                    w.pos_y = '1;
                end
            endcase
        end else if (r < 996) begin
            w.action = ACT_NONE;
        end else begin
            w.action = ACT_CLEAR;
        end
        return w;
    endfunction

    function automatic t_stim_row word_row(logic [1:0] act, int x, int y, logic [7:0] pix);
        t_stim_row r;
        r.kind        = ROW_WORD;
        r.idx         = '0;
        r.cfg_val     = '0;
        r.word.action = act;
        r.word.pos_x  = 16'(x);
        r.word.pos_y  = 16'(y);
        r.word.pixel  = pix;
        r.typed       = 1'b0;
        r.rect        = '0;
        return r;
    endfunction

    // A scan of a one-pixel frame at unit scale: one rectangle that also ends the frame.
    function automatic t_stim_row scan_expect(logic [15:0] color);
        t_stim_row r;
        r = word_row(ACT_SCAN, 0, 0, 8'h00);
        r.typed            = 1'b1;
        r.rect.rect_x      = 11'd0;
        r.rect.rect_y      = 11'd0;
        r.rect.rect_w      = 12'd1;
        r.rect.rect_h      = 5'd1;
        r.rect.rect_color  = color;
        r.rect.last_result = 1'b1;
        r.rect.frame_end   = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        t_stim_row r;
        r = word_row(ACT_NONE, 0, 0, 8'h00);
        r.kind    = ROW_CFG;
        r.idx     = idx;
        r.cfg_val = v;
        return r;
    endfunction

    // Offers one word, waits for it to be taken and records what it should produce.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_rect);
        t_out_word rects [2];
        int        n;
        int        gap;
        gap = pick_gap(tx_burst);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        n = fb_predict(w, rects);
        if (typed) begin
            rect_expect_q.push_back(typed_rect);
        end else begin
            for (int i = 0; i < n; i++) rect_expect_q.push_back(rects[i]);
        end
    endtask

    // Stops offering, waits for every rectangle, then lets a scan in flight finish.
    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (rect_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        fb_config(idx, d);
    endtask

    // Receiver pacing, with one long hold-off on request.
    initial begin : rx_pacing
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (rx_burst) begin
                out_if.ready <= 1'b1;
            end else begin
                stall_left = pick_gap(1'b0);
                out_if.ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Every rectangle taken is compared with the oldest one expected.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (rect_expect_q.size() == 0) begin
                if (n_err < MAX_REPORTS) begin
                    $display("%0t ns: rectangle with none expected: expected nothing, actual %p",
                             $time, out_if.data);
                end
                n_err++;
            end else begin
                want_rect = rect_expect_q.pop_front();
                check_field("rect_x", want_rect.rect_x, out_if.data.rect_x);
                check_field("rect_y", want_rect.rect_y, out_if.data.rect_y);
                check_field("rect_w", want_rect.rect_w, out_if.data.rect_w);
                check_field("rect_h", want_rect.rect_h, out_if.data.rect_h);
                check_field("rect_color", want_rect.rect_color, out_if.data.rect_color);
                check_field("last_result", want_rect.last_result, out_if.data.last_result);
                check_field("frame_end", want_rect.frame_end, out_if.data.frame_end);
            end
        end
    end

    // Watchdog: too many cycles without a word moving on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("framebuffer_run_span_scanout test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int       ph;
        int       n_words;
        t_in_word w;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        n_err        = 0;
        quiet_cycles = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        hold_off_req = 1'b0;

        // Shadow state as it stands after reset.
        foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
        scan_col_s  = 0;
        scan_row_s  = 0;
        run_start_s = 0;
        run_color_s = 16'h0000;
        mode_s      = 1'b1;
        width_s     = 8'd128;
        height_s    = 8'd128;
        sx_s        = 5'd1;
        sy_s        = 5'd1;

        directed_rows = '{
            // Mid-row scan at reset geometry closes no run.
            word_row(ACT_SCAN, 0, 0, 8'h00),
            // Zero extents saturate to a one-pixel frame.
            cfg_row(REG_WIDTH, 8'd0),
            cfg_row(REG_HEIGHT, 8'd0),
            scan_expect(16'h0000),
            word_row(ACT_WRITE, 0, 0, 8'hFF),
            scan_expect(16'hFFFF),
            // Writes outside the area are dropped.
            word_row(ACT_WRITE, -1, 0, 8'h11),
            word_row(ACT_WRITE, 0, -32768, 8'h22),
            word_row(ACT_WRITE, 32767, 0, 8'h33),
            word_row(ACT_WRITE, -32768, 32767, 8'h44),
            word_row(ACT_WRITE, 1, 0, 8'h55),
            scan_expect(16'hFFFF),
            // The spare action code does nothing.
            word_row(ACT_NONE, -1, -1, 8'hFF),
            word_row(ACT_CLEAR, 0, 0, 8'h00),
            scan_expect(16'h0000),
            // Grey spread of 0x80.
            cfg_row(REG_COLOR_MODE, 8'd0),
            word_row(ACT_WRITE, 0, 0, 8'h80),
            scan_expect(16'h8410),
            // Oversized extents saturate; an unknown index is ignored.
            cfg_row(REG_WIDTH, 8'd255),
            cfg_row(REG_HEIGHT, 8'd200),
            cfg_row(REG_NONE, 8'hFF),
            // A 3x2 frame at oversized and full scale: runs close on change and at row end.
            cfg_row(REG_WIDTH, 8'd3),
            cfg_row(REG_HEIGHT, 8'd2),
            cfg_row(REG_SCALE_X, 8'd31),
            cfg_row(REG_SCALE_Y, 8'd16),
            word_row(ACT_WRITE, 1, 0, 8'h80),
            word_row(ACT_WRITE, 2, 1, 8'h07),
            word_row(ACT_SCAN, 0, 0, 8'h00),
            word_row(ACT_SCAN, 0, 0, 8'h00),
            word_row(ACT_SCAN, 0, 0, 8'h00),
            word_row(ACT_SCAN, 0, 0, 8'h00),
            word_row(ACT_SCAN, 0, 0, 8'h00),
            word_row(ACT_SCAN, 0, 0, 8'h00)
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(directed_rows[i].idx, directed_rows[i].cfg_val);
            end else begin
                send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].rect);
            end
        end

        // Random phases, each under its own register settings.
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            cfg_write(REG_COLOR_MODE, 8'($urandom_range(0, 255)));
            cfg_write(REG_SCALE_X, pick_scale());
            cfg_write(REG_SCALE_Y, pick_scale());
            if (ph == 2) begin
                cfg_write(REG_WIDTH, 8'd4);
                cfg_write(REG_HEIGHT, 8'd3);
            end else if (ph == 5) begin
                cfg_write(REG_WIDTH, 8'd255);
                cfg_write(REG_HEIGHT, 8'd128);
            end else if (ph == 8) begin
                cfg_write(REG_WIDTH, 8'd128);
                cfg_write(REG_HEIGHT, 8'd1);
            end else if (ph == 0 || $urandom_range(0, 1)) begin
                cfg_write(REG_WIDTH, pick_extent(10));
                cfg_write(REG_HEIGHT, pick_extent(6));
            end
            if ($urandom_range(0, 3) == 0) cfg_write(REG_NONE, 8'($urandom));

            // In one phase the receiver holds off while words keep coming.
            tx_burst     = ($urandom_range(0, 3) == 0) || (ph == 2);
            rx_burst     = ($urandom_range(0, 3) == 0) && (ph != 2);
            hold_off_req = (ph == 2);

            n_words = 0;
            while (n_words < PHASE_WORDS) begin
                w = random_word();
                send_word(w, 1'b0, '0);
                if (w.action != ACT_NONE) n_words++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("framebuffer_run_span_scanout test passed");
        end else begin
            $display("framebuffer_run_span_scanout test failed");
        end
        $finish;
    end

endmodule
